@@ rtl/qrs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared types and constants for the quadratic root solver.
// ----------------------------------------------------------------------------
package qrs_pkg;

  localparam int DISC_W = 66;  // magnitude of b*b - 4*a*c
  localparam int SQRT_W = 34;  // floor square root of the discriminant
  localparam int DEN_W  = 33;  // divisor: 2*|a| or |b|
  localparam int QUO_W  = 33;  // quotient bits formed before the overflow check
  localparam int APB_AW = 2;

  localparam logic [APB_AW-1:0] REG_TOL = 2'd0;

  localparam logic [1:0] OUT_ROOTS = 2'd0;
  localparam logic [1:0] OUT_NONE  = 2'd1;
  localparam logic [1:0] OUT_INF   = 2'd2;

  localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] NEG_MAX = 32'h8000_0000;

  typedef enum logic [2:0] {
    CLS_NONE,
    CLS_INF,
    CLS_LIN,
    CLS_ONE,
    CLS_TWO
  } cls_t;

  typedef struct packed {
    logic signed [31:0] coef_quad;
    logic signed [31:0] coef_lin;
    logic signed [31:0] coef_const;
  } coef_t;

  typedef struct packed {
    logic [1:0]         outcome;
    logic [1:0]         num_roots;
    logic signed [31:0] root_first;
    logic signed [31:0] root_second;
    logic               saturated;
  } root_t;

  typedef struct packed {
    cls_t               cls;
    logic               neg_quad;
    logic               neg_lin;
    logic               neg_const;
    logic [31:0]        mag_quad;
    logic [31:0]        mag_lin;
    logic [31:0]        mag_const;
    logic signed [31:0] lin;
    logic [DISC_W-1:0]  disc;
  } job_t;

  function automatic logic [31:0] mag32(logic [31:0] x);
    return x[31] ? (~x + 32'd1) : x;
  endfunction

endpackage

@@ rtl/qrs_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_front
// Takes coefficient sets, forms the discriminant and classifies each one.
// ----------------------------------------------------------------------------
module qrs_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  qrs_pkg::coef_t     coef,
  input  logic [30:0]        tolerance,
  output logic               job_valid,
  output qrs_pkg::job_t      job
);

  localparam int DW = qrs_pkg::DISC_W;

  // stage 1: magnitudes and near-zero tests
  logic        s1_valid;
  logic        s1_neg_a, s1_neg_b, s1_neg_c;
  logic [31:0] s1_mag_a, s1_mag_b, s1_mag_c;
  logic        s1_nz_a, s1_nz_b, s1_nz_c;
  logic [31:0] s1_lin;
  logic [31:0] ma, mb, mc;

  assign ma = qrs_pkg::mag32(coef.coef_quad);
  assign mb = qrs_pkg::mag32(coef.coef_lin);
  assign mc = qrs_pkg::mag32(coef.coef_const);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_neg_a <= coef.coef_quad[31];
      s1_neg_b <= coef.coef_lin[31];
      s1_neg_c <= coef.coef_const[31];
      s1_mag_a <= ma;
      s1_mag_b <= mb;
      s1_mag_c <= mc;
      s1_nz_a  <= (ma == 32'd0) || (ma < {1'b0, tolerance});
      s1_nz_b  <= (mb == 32'd0) || (mb < {1'b0, tolerance});
      s1_nz_c  <= (mc == 32'd0) || (mc < {1'b0, tolerance});
      s1_lin   <= coef.coef_lin;
    end
  end

  // stage 2: products
  logic        s2_valid;
  logic [63:0] s2_bb, s2_ac;
  logic        s2_ac_neg;
  logic        s2_neg_a, s2_neg_b, s2_neg_c;
  logic [31:0] s2_mag_a, s2_mag_b, s2_mag_c;
  logic        s2_nz_a, s2_nz_b, s2_nz_c;
  logic [31:0] s2_lin;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_bb     <= s1_mag_b * s1_mag_b;
      s2_ac     <= s1_mag_a * s1_mag_c;
      s2_ac_neg <= s1_neg_a ^ s1_neg_c;
      s2_neg_a  <= s1_neg_a;
      s2_neg_b  <= s1_neg_b;
      s2_neg_c  <= s1_neg_c;
      s2_mag_a  <= s1_mag_a;
      s2_mag_b  <= s1_mag_b;
      s2_mag_c  <= s1_mag_c;
      s2_nz_a   <= s1_nz_a;
      s2_nz_b   <= s1_nz_b;
      s2_nz_c   <= s1_nz_c;
      s2_lin    <= s1_lin;
    end
  end

  // stage 3: discriminant and class
  logic [DW-1:0] bb_w, ac4, d_sum, eps_d, d_mag;
  logic [DW:0]   d_diff;
  logic          d_neg, d_zero;
  qrs_pkg::cls_t cls;

  assign bb_w   = DW'(s2_bb);
  assign ac4    = {s2_ac, 2'b00};
  assign d_sum  = bb_w + ac4;
  assign d_diff = {1'b0, bb_w} - {1'b0, ac4};
  assign d_neg  = !s2_ac_neg && d_diff[DW];
  assign d_mag  = s2_ac_neg ? d_sum : (d_diff[DW] ? (ac4 - bb_w) : d_diff[DW-1:0]);
  assign eps_d  = DW'(tolerance) << FRAC_BITS;
  assign d_zero = (d_mag == '0) || (d_mag < eps_d);

  always_comb begin
    if (s2_nz_a) begin
      if (s2_nz_b) begin
        cls = s2_nz_c ? qrs_pkg::CLS_INF : qrs_pkg::CLS_NONE;
      end else begin
        cls = qrs_pkg::CLS_LIN;
      end
    end else if (d_zero) begin
      cls = qrs_pkg::CLS_ONE;
    end else if (d_neg) begin
      cls = qrs_pkg::CLS_NONE;
    end else begin
      cls = qrs_pkg::CLS_TWO;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (en) begin
      job_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      job.cls       <= cls;
      job.neg_quad  <= s2_neg_a;
      job.neg_lin   <= s2_neg_b;
      job.neg_const <= s2_neg_c;
      job.mag_quad  <= s2_mag_a;
      job.mag_lin   <= s2_mag_b;
      job.mag_const <= s2_mag_c;
      job.lin       <= s2_lin;
      job.disc      <= d_mag;
    end
  end

endmodule

@@ rtl/qrs_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_fifo
// Short queue of classified jobs between the front and back parts.
// ----------------------------------------------------------------------------
module qrs_fifo #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  qrs_pkg::job_t push_job,
  input  logic          pop,
  output logic          full,
  output logic          not_empty,
  output qrs_pkg::job_t head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  qrs_pkg::job_t  slots [DEPTH];
  logic [AW-1:0]  wr_ptr, rd_ptr;
  logic [CW-1:0]  count;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule

@@ rtl/qrs_sqrt.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_sqrt
// Pipelined floor square root of the discriminant, one result bit a stage.
// ----------------------------------------------------------------------------
module qrs_sqrt (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  qrs_pkg::job_t                in_job,
  output logic                         out_valid,
  output logic [qrs_pkg::SQRT_W-1:0]   root,
  output qrs_pkg::job_t                out_job
);

  localparam int STEPS = qrs_pkg::SQRT_W;
  localparam int RAD_W = 2 * STEPS;
  localparam int REM_W = STEPS + 3;

  logic [STEPS-1:0] vld;
  logic [STEPS-1:0] rt  [STEPS];
  logic [REM_W-1:0] rm  [STEPS];
  logic [RAD_W-1:0] rd  [STEPS];
  qrs_pkg::job_t    jb  [STEPS];

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic             v_in;
    logic [STEPS-1:0] root_in;
    logic [REM_W-1:0] rem_in, rem_sh, trial;
    logic [RAD_W-1:0] rad_in;
    qrs_pkg::job_t    job_in;

    if (i == 0) begin : g_first
      assign v_in    = in_valid;
      assign root_in = '0;
      assign rem_in  = '0;
      assign rad_in  = RAD_W'(in_job.disc);
      assign job_in  = in_job;
    end else begin : g_next
      assign v_in    = vld[i-1];
      assign root_in = rt[i-1];
      assign rem_in  = rm[i-1];
      assign rad_in  = rd[i-1];
      assign job_in  = jb[i-1];
    end

    // bring down the next two radicand bits and try root*4+1
    assign rem_sh = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
    assign trial  = {1'b0, root_in, 2'b01};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rd[i] <= rad_in << 2;
        jb[i] <= job_in;
        if (rem_sh >= trial) begin
          rm[i] <= rem_sh - trial;
          rt[i] <= {root_in[STEPS-2:0], 1'b1};
        end else begin
          rm[i] <= rem_sh;
          rt[i] <= {root_in[STEPS-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = vld[STEPS-1];
  assign root      = rt[STEPS-1];
  assign out_job   = jb[STEPS-1];

endmodule

@@ rtl/qrs_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_div
// Pipelined restoring divider with sign and saturation to 32 bits.
// ----------------------------------------------------------------------------
module qrs_div #(
  parameter int NUM_W = 50,
  parameter int TAG_W = 3
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic                        neg,
  input  logic [NUM_W-1:0]            num,
  input  logic [qrs_pkg::DEN_W-1:0]   den,
  input  logic [TAG_W-1:0]            tag,
  output logic                        out_valid,
  output logic [31:0]                 quo,
  output logic                        sat,
  output logic [TAG_W-1:0]            out_tag
);

  localparam int DW = qrs_pkg::DEN_W;
  localparam int QW = qrs_pkg::QUO_W;

  logic [QW:0]    vld;
  logic [DW-1:0]  rm   [QW+1];
  logic [QW-1:0]  lo   [QW+1];
  logic [DW-1:0]  dn   [QW+1];
  logic           ng   [QW+1];
  logic           ov   [QW+1];
  logic [TAG_W-1:0] tg [QW+1];
  logic [DW-1:0]  hi;

  assign hi = DW'(num[NUM_W-1:QW]);

  // entry stage: quotient of 2^QW or more can only saturate
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rm[0] <= hi;
      lo[0] <= num[QW-1:0];
      dn[0] <= den;
      ng[0] <= neg;
      ov[0] <= (hi >= den);
      tg[0] <= tag;
    end
  end

  for (genvar i = 1; i <= QW; i++) begin : g_step
    logic [DW:0] rem_sh;
    logic        take;

    assign rem_sh = {rm[i-1], lo[i-1][QW-1]};
    assign take   = (rem_sh >= {1'b0, dn[i-1]});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= vld[i-1];
      end
    end

    // low word shifts numerator bits out and quotient bits in
    always_ff @(posedge clk) begin
      if (en) begin
        rm[i] <= take ? DW'(rem_sh - {1'b0, dn[i-1]}) : DW'(rem_sh);
        lo[i] <= {lo[i-1][QW-2:0], take};
        dn[i] <= dn[i-1];
        ng[i] <= ng[i-1];
        ov[i] <= ov[i-1];
        tg[i] <= tg[i-1];
      end
    end
  end

  logic [QW-1:0] q;
  logic [31:0]   q_res;
  logic          q_sat;

  assign q = lo[QW];

  always_comb begin
    if (!ng[QW]) begin
      q_sat = ov[QW] || (q > QW'(qrs_pkg::POS_MAX));
      q_res = q_sat ? qrs_pkg::POS_MAX : q[31:0];
    end else begin
      q_sat = ov[QW] || (q > QW'(qrs_pkg::NEG_MAX));
      q_res = q_sat ? qrs_pkg::NEG_MAX : (~q[31:0] + 32'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo     <= q_res;
      sat     <= q_sat;
      out_tag <= tg[QW];
    end
  end

endmodule

@@ rtl/qrs_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_back
// Square root, root division and result assembly for queued jobs.
// ----------------------------------------------------------------------------
module qrs_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           job_valid,
  input  qrs_pkg::job_t  job,
  output logic           pop,
  output logic           root_valid,
  input  logic           root_stall,
  output qrs_pkg::root_t root
);

  localparam int SW    = qrs_pkg::SQRT_W;
  localparam int MW    = SW;              // magnitude of -b +- sqrt(D)
  localparam int NUM_W = MW + FRAC_BITS;
  localparam int DW    = qrs_pkg::DEN_W;
  localparam int CLS_W = $bits(qrs_pkg::cls_t);

  logic en;

  // whole back part holds while the result waits
  assign en  = !(root_valid && root_stall);
  assign pop = en && job_valid;

  logic          sq_valid;
  logic [SW-1:0] sq_root;
  qrs_pkg::job_t sq_job;

  qrs_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (pop),
    .in_job    (job),
    .out_valid (sq_valid),
    .root      (sq_root),
    .out_job   (sq_job)
  );

  // setup stage: numerators and divisors for both roots
  logic signed [MW:0] nb, n_plus, n_minus, n1;
  logic [MW-1:0]      m1, m2;
  logic               lin_neg;

  assign nb      = -(MW+1)'(sq_job.lin);
  assign n_plus  = nb + $signed({1'b0, sq_root});
  assign n_minus = nb - $signed({1'b0, sq_root});
  assign n1      = (sq_job.cls == qrs_pkg::CLS_TWO) ? n_plus : nb;
  assign m1      = n1[MW] ? MW'(-n1) : n1[MW-1:0];
  assign m2      = n_minus[MW] ? MW'(-n_minus) : n_minus[MW-1:0];
  assign lin_neg = (sq_job.neg_const == sq_job.neg_lin) && (sq_job.mag_const != 32'd0);

  logic             su_valid, su_neg1, su_neg2, su_two;
  logic [NUM_W-1:0] su_num1, su_num2;
  logic [DW-1:0]    su_den1, su_den2;
  qrs_pkg::cls_t    su_cls;

  always_ff @(posedge clk) begin
    if (rst) begin
      su_valid <= 1'b0;
    end else if (en) begin
      su_valid <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      su_cls  <= sq_job.cls;
      su_two  <= (sq_job.cls == qrs_pkg::CLS_TWO);
      su_num2 <= {m2, FRAC_BITS'(0)};
      su_neg2 <= n_minus[MW] ^ sq_job.neg_quad;
      su_den2 <= {sq_job.mag_quad, 1'b0};
      if (sq_job.cls == qrs_pkg::CLS_LIN) begin
        su_num1 <= {(MW-32)'(0), sq_job.mag_const, FRAC_BITS'(0)};
        su_neg1 <= lin_neg;
        su_den1 <= {1'b0, sq_job.mag_lin};
      end else begin
        su_num1 <= {m1, FRAC_BITS'(0)};
        su_neg1 <= n1[MW] ^ sq_job.neg_quad;
        su_den1 <= {sq_job.mag_quad, 1'b0};
      end
    end
  end

  logic             d1_valid, d2_valid, d1_sat, d2_sat;
  logic [31:0]      d1_quo, d2_quo;
  logic [CLS_W-1:0] d1_tag;
  logic             d2_two;

  qrs_div #(.NUM_W(NUM_W), .TAG_W(CLS_W)) u_div_first (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (su_valid),
    .neg       (su_neg1),
    .num       (su_num1),
    .den       (su_den1),
    .tag       (su_cls),
    .out_valid (d1_valid),
    .quo       (d1_quo),
    .sat       (d1_sat),
    .out_tag   (d1_tag)
  );

  qrs_div #(.NUM_W(NUM_W), .TAG_W(1)) u_div_second (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (su_valid),
    .neg       (su_neg2),
    .num       (su_num2),
    .den       (su_den2),
    .tag       (su_two),
    .out_valid (d2_valid),
    .quo       (d2_quo),
    .sat       (d2_sat),
    .out_tag   (d2_two)
  );

  qrs_pkg::root_t res;
  qrs_pkg::cls_t  d_cls;

  assign d_cls = qrs_pkg::cls_t'(d1_tag);

  always_comb begin
    res = '0;
    case (d_cls) inside
      qrs_pkg::CLS_NONE: res.outcome = qrs_pkg::OUT_NONE;
      qrs_pkg::CLS_INF:  res.outcome = qrs_pkg::OUT_INF;
      qrs_pkg::CLS_LIN, qrs_pkg::CLS_ONE: begin
        res.outcome    = qrs_pkg::OUT_ROOTS;
        res.num_roots  = 2'd1;
        res.root_first = d1_quo;
        res.saturated  = d1_sat;
      end
      default: begin
        res.outcome     = qrs_pkg::OUT_ROOTS;
        res.num_roots   = 2'd2;
        res.root_first  = d1_quo;
        res.root_second = d2_two ? d2_quo : 32'd0;
        res.saturated   = d1_sat | (d2_two & d2_sat);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      root_valid <= 1'b0;
    end else if (en) begin
      root_valid <= d1_valid && d2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      root <= res;
    end
  end

endmodule

@@ rtl/quadratic_root_solver.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadratic_root_solver
// Real roots of a*x^2 + b*x + c = 0 for signed fixed-point coefficients.
// ----------------------------------------------------------------------------
// Accepts one coefficient set per clock and returns one result per set, in
// order. A set passes through 3 front stages that classify and form the
// discriminant, the job queue, 34 stages of the bit-per-stage square root, a
// setup stage, 35 stages in each of the two parallel dividers (entry, 33
// quotient bits, saturation) and the output register. A stalled result holds
// the whole back part; the queue then fills and the input stalls.
// The tolerance register at byte address 0 may be written only while no
// transaction is in flight.
module quadratic_root_solver #(
  parameter int FRAC_BITS   = 16,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       coef_valid,
  output logic                       coef_stall,
  input  qrs_pkg::coef_t             coef,
  output logic                       root_valid,
  input  logic                       root_stall,
  output qrs_pkg::root_t             root,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [qrs_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  logic [30:0] tolerance;

  assign pready = 1'b1;
  assign prdata = (paddr == qrs_pkg::REG_TOL) ? {1'b0, tolerance} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= 31'd1;
    end else if (psel && penable && pwrite && pready && (paddr == qrs_pkg::REG_TOL)) begin
      tolerance <= pwdata[30:0];
    end
  end

  logic          q_full, q_not_empty, q_pop, front_en;
  logic          f_valid;
  qrs_pkg::job_t f_job, q_head;

  assign front_en   = !q_full;
  assign coef_stall = q_full;

  qrs_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (front_en),
    .in_valid  (coef_valid),
    .coef      (coef),
    .tolerance (tolerance),
    .job_valid (f_valid),
    .job       (f_job)
  );

  qrs_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (f_valid && front_en),
    .push_job  (f_job),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  qrs_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .job_valid  (q_not_empty),
    .job        (q_head),
    .pop        (q_pop),
    .root_valid (root_valid),
    .root_stall (root_stall),
    .root       (root)
  );

endmodule

@@ rtl/qrs_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_checker
// Port-level checks for the quadratic root solver.
// ----------------------------------------------------------------------------
module qrs_checker (
  input logic           clk,
  input logic           rst,
  input logic           root_valid,
  input logic           root_stall,
  input qrs_pkg::root_t root,
  input logic           pready
);

  // a stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    root_valid && root_stall |=> root_valid)
    else $error("result dropped while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !root_valid)
    else $error("result valid after reset");

  a_ready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready low");

  // no roots reported with a no-solution or infinite outcome
  a_empty: assert property (@(posedge clk) disable iff (rst)
    root_valid && (root.outcome != qrs_pkg::OUT_ROOTS) |->
      (root.num_roots == 2'd0) && (root.root_first == 32'sd0) &&
      (root.root_second == 32'sd0) && !root.saturated)
    else $error("fields set without roots");

  a_single: assert property (@(posedge clk) disable iff (rst)
    root_valid && (root.num_roots == 2'd1) |-> (root.root_second == 32'sd0))
    else $error("second root set for single root");

endmodule

bind quadratic_root_solver qrs_checker u_qrs_checker (
  .clk        (clk),
  .rst        (rst),
  .root_valid (root_valid),
  .root_stall (root_stall),
  .root       (root),
  .pready     (pready)
);

@@ test/quadratic_root_solver_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadratic_root_solver_test
// Self-checking bench for the quadratic root solver: a bursty coefficient
// driver, a stalling result monitor, and an in-bench predictor of the roots.
// ----------------------------------------------------------------------------
module quadratic_root_solver_test;

  localparam int FRAC_BITS = 16;
  localparam int IDLE_LIMIT = 5000;

  logic                       clk;
  logic                       rst;
  logic                       coef_valid;
  logic                       coef_stall;
  qrs_pkg::coef_t             coef;
  logic                       root_valid;
  logic                       root_stall;
  qrs_pkg::root_t             root;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [qrs_pkg::APB_AW-1:0] paddr;
  logic [31:0]                pwdata;
  logic [31:0]                prdata;
  logic                       pready;

  quadratic_root_solver #(.FRAC_BITS(FRAC_BITS)) u_dut (
    .clk(clk), .rst(rst),
    .coef_valid(coef_valid), .coef_stall(coef_stall), .coef(coef),
    .root_valid(root_valid), .root_stall(root_stall), .root(root),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  qrs_pkg::coef_t pending_coefs[$];
  qrs_pkg::root_t expected_roots[$];
  logic [30:0]    tol;
  int             errors;
  int             checked;
  int             sent;
  int             idle_cycles;
  int             burst_left;
  int             gap_left;
  int             stall_mode;
  logic           in_taken;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] abs64(longint x);
    return x < 0 ? 64'(-x) : 64'(x);
  endfunction

  function automatic bit is_small(longint x);
    return x == 0 || abs64(x) < {33'd0, tol};
  endfunction

  // truncating divide with saturation to 32-bit signed
  function automatic logic [31:0] sat_div(bit neg, logic [127:0] num,
                                          logic [127:0] den, ref bit sat);
    logic [127:0] q;
    q = num / den;
    if (!neg) begin
      if (q > 128'h7FFF_FFFF) begin
        sat = 1'b1;
        q = 128'h7FFF_FFFF;
      end
      return q[31:0];
    end
    if (q > 128'h8000_0000) begin
      sat = 1'b1;
      q = 128'h8000_0000;
    end
    return 32'(-q[31:0]);
  endfunction

  function automatic logic [31:0] root_over_2a(longint num, longint a, ref bit sat);
    return sat_div((num < 0) != (a < 0), {64'd0, abs64(num)} << FRAC_BITS,
                   {64'd0, abs64(a)} << 1, sat);
  endfunction

  function automatic logic [33:0] floor_sqrt(logic [127:0] d);
    logic [33:0] r;
    logic [33:0] cand;
    r = '0;
    for (int i = 33; i >= 0; i--) begin
      cand = r | (34'd1 << i);
      if ({94'd0, cand} * {94'd0, cand} <= d) r = cand;
    end
    return r;
  endfunction

  function automatic qrs_pkg::root_t solve_roots(qrs_pkg::coef_t c);
    qrs_pkg::root_t r;
    longint         a, b, k;
    logic [127:0]   disc_pos, pos_part, neg_part;
    logic [33:0]    s;
    bit             sat;
    a = longint'(c.coef_quad);
    b = longint'(c.coef_lin);
    k = longint'(c.coef_const);
    r = '0;
    sat = 1'b0;
    r.outcome = qrs_pkg::OUT_ROOTS;
    if (is_small(a)) begin
      if (is_small(b)) begin
        r.outcome = is_small(k) ? qrs_pkg::OUT_INF : qrs_pkg::OUT_NONE;
      end else begin
        r.root_first = sat_div((k < 0) == (b < 0) && k != 0,
                               {64'd0, abs64(k)} << FRAC_BITS, {64'd0, abs64(b)}, sat);
        r.num_roots = 2'd1;
      end
    end else begin
      pos_part = {64'd0, abs64(b)} * {64'd0, abs64(b)};
      neg_part = 128'(4) * ({64'd0, abs64(a)} * {64'd0, abs64(k)});
      if ((a < 0) != (k < 0)) pos_part = pos_part + neg_part;
      else neg_part = neg_part;
      if ((a < 0) != (k < 0) || neg_part == 0) begin
        disc_pos = pos_part;
        neg_part = 0;
      end
      if (neg_part != 0 && neg_part > pos_part) begin
        disc_pos = neg_part - pos_part;
        if (disc_pos < ({97'd0, tol} << FRAC_BITS)) begin
          r.root_first = root_over_2a(-b, a, sat);
          r.num_roots = 2'd1;
        end else begin
          r.outcome = qrs_pkg::OUT_NONE;
        end
      end else begin
        if (neg_part != 0) disc_pos = pos_part - neg_part;
        if (disc_pos == 0 || disc_pos < ({97'd0, tol} << FRAC_BITS)) begin
          r.root_first = root_over_2a(-b, a, sat);
          r.num_roots = 2'd1;
        end else begin
          s = floor_sqrt(disc_pos);
          r.root_first = root_over_2a(-b + longint'(s), a, sat);
          r.root_second = root_over_2a(-b - longint'(s), a, sat);
          r.num_roots = 2'd2;
        end
      end
    end
    r.saturated = sat;
    return r;
  endfunction

  // driver: bursts with random gaps
  always @(negedge clk) begin
    if (rst) begin
      coef_valid <= 1'b0;
    end else if (coef_valid && !in_taken) begin
      // hold
    end else begin
      if (coef_valid) begin
        void'(pending_coefs.pop_front());
      end
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        coef_valid <= 1'b0;
      end else if (pending_coefs.size() > 0) begin
        coef_valid <= 1'b1;
        coef <= pending_coefs[0];
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 30);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        coef_valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern
  always @(negedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: root_stall <= 1'b0;
      1: root_stall <= ($urandom_range(0, 3) == 0);
      2: root_stall <= ($urandom_range(0, 1) == 0);
      default: root_stall <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // prediction and checking at the rising edge
  always @(posedge clk) begin
    in_taken <= coef_valid && !coef_stall;
    if (!rst) begin
      if ((coef_valid && !coef_stall) || (root_valid && !root_stall)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (coef_valid && !coef_stall) begin
        expected_roots.push_back(solve_roots(coef));
        sent <= sent + 1;
      end
      if (root_valid && !root_stall) begin
        if (expected_roots.size() == 0) begin
          $display("%0t: unexpected transaction %p", $time, root);
          errors <= errors + 1;
        end else begin
          if (root !== expected_roots[0]) begin
            $display("%0t: mismatch expected %p actual %p", $time, expected_roots[0], root);
            errors <= errors + 1;
          end
          void'(expected_roots.pop_front());
          checked <= checked + 1;
        end
      end
      if (idle_cycles > IDLE_LIMIT) begin
        $display("%0t: watchdog expired, %0d outstanding", $time, expected_roots.size());
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic write_tol(logic [30:0] v);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= qrs_pkg::REG_TOL;
    pwdata <= {1'b0, v};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    tol = v;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic drain();
    while (pending_coefs.size() != 0 || expected_roots.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coef(int sel);
    case (sel)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      2: return 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
      3: return ($urandom_range(0, 1)) ? 32'h7FFF_FFFF : 32'h8000_0000;
      4: return 32'($signed($urandom_range(0, 8)) - 4);
      default: return 32'($signed($urandom_range(0, 1 << 17)) - (1 << 16));
    endcase
  endfunction

  task automatic add_set(logic [31:0] qa, logic [31:0] lb, logic [31:0] kc);
    qrs_pkg::coef_t c;
    c.coef_quad = qa;
    c.coef_lin = lb;
    c.coef_const = kc;
    pending_coefs.push_back(c);
  endtask

  task automatic random_phase(int n);
    logic [31:0] qa, lb, kc, s;
    for (int i = 0; i < n; i++) begin
      qa = rand_coef($urandom_range(0, 5));
      lb = rand_coef($urandom_range(0, 5));
      kc = rand_coef($urandom_range(0, 5));
      case ($urandom_range(0, 7))
        0: qa = 32'($signed($urandom_range(0, 6)) - 3);
        1: begin
          // perfect square b^2 = 4ac gives a double root
          s = $urandom_range(1, 2000);
          qa = s;
          kc = s;
          lb = ($urandom_range(0, 1)) ? 32'(2 * s) : 32'(-2 * s);
        end
        2: begin
          qa = 32'h10000;
          lb = rand_coef(5);
          kc = 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
        end
        default: ;
      endcase
      add_set(qa, lb, kc);
    end
  endtask

  initial begin
    rst = 1'b1;
    coef_valid = 1'b0;
    coef = '0;
    root_stall = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = qrs_pkg::REG_TOL;
    pwdata = '0;
    tol = 31'd1;
    errors = 0;
    checked = 0;
    sent = 0;
    idle_cycles = 0;
    burst_left = 0;
    gap_left = 0;
    stall_mode = 0;
    in_taken = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: linear, degenerate, double root, complex, extremes
    add_set(32'h0, 32'h0, 32'h0);
    add_set(32'h0, 32'h0, 32'h1);
    add_set(32'h0, 32'h0002_0000, 32'hFFFC_0000);
    add_set(32'h0, 32'h1, 32'h7FFF_FFFF);
    add_set(32'h0, 32'hFFFF_FFFF, 32'h8000_0000);
    add_set(32'h0001_0000, 32'hFFFD_0000, 32'h0002_0000);
    add_set(32'h0001_0000, 32'h0002_0000, 32'h0001_0000);
    add_set(32'h0001_0000, 32'h0, 32'h0001_0000);
    add_set(32'h1, 32'h7FFF_FFFF, 32'h8000_0000);
    add_set(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    add_set(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    add_set(32'h1, 32'h0, 32'h8000_0000);
    add_set(32'hFFFF_FFFF, 32'h0, 32'h0);
    add_set(32'h1, 32'h2, 32'h1);
    add_set(32'h0001_0000, 32'h0, 32'h0);
    drain();
    random_phase(300);
    drain();

    write_tol(31'd0);
    add_set(32'h0, 32'h0, 32'h0);
    add_set(32'h0, 32'h0, 32'h1);
    add_set(32'h1, 32'h2, 32'h1);
    random_phase(200);
    drain();

    // near boundary for the negative discriminant test
    write_tol(31'd4);
    add_set(32'h1, 32'h0, 32'h1);
    add_set(32'h1, 32'h2, 32'h2);
    add_set(32'h3, 32'h0, 32'h0);
    random_phase(200);
    drain();

    write_tol(31'h7FFF_FFFF);
    add_set(32'h7FFF_FFFF, 32'h8000_0000, 32'h1);
    add_set(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    random_phase(100);
    drain();

    write_tol(31'($urandom_range(0, 1 << 16)));
    random_phase(200);
    drain();

    $display("checked %0d results from %0d coefficient sets over five tolerance settings",
             checked, sent);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
